[src/ffsa_pkg.sv]
// shared constants, types and codes of the first-fit segment allocator
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 16;
    localparam int SIZE_BITS    = 16;
    localparam int IDX_W        = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int ID_W         = 16;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic                 used;
        logic [ID_W-1:0]      owner;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_FREE     = 2'd1;
    localparam logic [1:0] CMD_COALESCE = 2'd2;
    localparam logic [1:0] CMD_NONE     = 2'd3;

    localparam logic [2:0] ST_ALLOCATED = 3'd0;
    localparam logic [2:0] ST_NO_FIT    = 3'd1;
    localparam logic [2:0] ST_FREED     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_COALESCED = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

endpackage

[src/ffsa_ram.sv]
// generic single-write, single-read ram with registered read data
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/first_fit_segment_allocator.sv]
// top level of the first-fit segment allocator: sequencer around the segment table ram
//
//  channel   signals                            direction  transaction
//  command   start, busy, cmd, req_size,        in         start && !busy && !total_size_we
//            free_id
//  result    done, status, out_id, out_size     out        done (one cycle)
//  config    total_size_we, total_size          in         total_size_we && !busy
//
// each table entry is handled as a ram read, then an evaluate step; allocate scans to the
// first fit and marks it used, on a split first shifting the entries after it up by one to
// make room for the rest; a split on a full table ends with the full status at the fit, and
// a zero request is rejected up front; free scans to the matching id; no fit and an unknown
// id scan all seg_count entries; coalesce walks every entry, then writes the last segment
// busy is already low while done shows, so the next transaction can go at the edge ending it
// after reset the table ram gets entry zero written in the init state, busy is high meanwhile
// entries at or beyond seg_count are never read, so they are not cleared
// the result strobe lasts one cycle and cannot be stalled
module first_fit_segment_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] req_size,
    input  logic [15:0] free_id,
    input  logic        total_size_we,
    input  logic [15:0] total_size,
    output logic        done,
    output logic [2:0]  status,
    output logic [15:0] out_id,
    output logic [15:0] out_size
);

    localparam int IW = ffsa_pkg::IDX_W;
    localparam int CW = ffsa_pkg::CNT_W;
    localparam int SB = ffsa_pkg::SIZE_BITS;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_SH_RD, S_SH_EV,
        S_SPLIT, S_MARK, S_C_RD, S_C_EV, S_C_END
    } state_t;

    state_t state_reg;

    logic [1:0]                  cmd_reg;
    logic [SB-1:0]               want_reg;
    logic [15:0]                 fid_reg;
    logic [IW-1:0]               idx_reg;     // scan / coalesce read pointer
    logic [IW-1:0]               jr_reg;      // shift source pointer
    logic [IW-1:0]               wr_reg;      // coalesce write pointer
    logic [SB-1:0]               seg_sz_reg;  // size of the fitting segment
    logic [CW-1:0]               count_reg;
    logic [15:0]                 id_reg;
    logic                        have_reg;
    ffsa_pkg::entry_t            acc_reg;
    logic                        done_reg;
    logic [2:0]                  status_reg;
    logic [15:0]                 out_id_reg;
    logic [15:0]                 out_size_reg;

    // ram port
    logic                        ram_we;
    logic [IW-1:0]               ram_waddr;
    ffsa_pkg::entry_t            ram_wdata;
    logic [IW-1:0]               ram_raddr;
    logic [ffsa_pkg::ENTRY_W-1:0] ram_rdata;
    ffsa_pkg::entry_t            ent;

    logic                        last;        // current index is the final table entry
    logic                        merge;
    logic                        alloc_hit;
    logic                        free_hit;

    assign ent       = ffsa_pkg::entry_t'(ram_rdata);
    assign last      = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign merge     = have_reg && !ent.used && !acc_reg.used;
    assign alloc_hit = !ent.used && (ent.size >= want_reg);
    assign free_hit  = ent.used && (ent.owner == fid_reg) && (fid_reg != 16'd0);
    assign ram_raddr = (state_reg == S_SH_RD) ? jr_reg : idx_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ent;
        case (state_reg)
            S_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{size: SB'(16'hFFFF), used: 1'b0, owner: '0};
            end
            S_IDLE:
            begin
                // table reinit on a total size write
                ram_we    = total_size_we;
                ram_waddr = '0;
                ram_wdata = '{size: SB'(total_size), used: 1'b0, owner: '0};
            end
            S_SCAN_EV:
            begin
                // release a matching segment in place
                ram_we    = (cmd_reg == ffsa_pkg::CMD_FREE) && free_hit;
                ram_waddr = idx_reg;
                ram_wdata = '{size: ent.size, used: 1'b0, owner: '0};
            end
            S_SH_EV:
            begin
                ram_we    = 1'b1;
                ram_waddr = jr_reg + IW'(1);
                ram_wdata = ent;
            end
            S_SPLIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg + IW'(1);
                ram_wdata = '{size: seg_sz_reg - want_reg, used: 1'b0, owner: '0};
            end
            S_MARK:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = '{size: want_reg, used: 1'b1, owner: id_reg};
            end
            S_C_EV:
            begin
                ram_we    = have_reg && !merge;
                ram_waddr = wr_reg;
                ram_wdata = acc_reg;
            end
            S_C_END:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_reg;
                ram_wdata = acc_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    ffsa_ram #(
        .WIDTH (ffsa_pkg::ENTRY_W),
        .DEPTH (ffsa_pkg::MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            count_reg    <= CW'(1);
            id_reg       <= 16'd1;
            done_reg     <= 1'b0;
            have_reg     <= 1'b0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            jr_reg       <= '0;
            cmd_reg      <= ffsa_pkg::CMD_NONE;
            status_reg   <= '0;
            out_id_reg   <= '0;
            out_size_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    count_reg <= CW'(1);
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (total_size_we)
                    begin
                        count_reg <= CW'(1);
                    end
                    else if (start)
                    begin
                        cmd_reg  <= cmd;
                        want_reg <= SB'(req_size);
                        fid_reg  <= free_id;
                        idx_reg  <= '0;
                        wr_reg   <= '0;
                        have_reg <= 1'b0;
                        case (cmd)
                            ffsa_pkg::CMD_ALLOC:
                            begin
                                if (SB'(req_size) == '0)
                                begin
                                    // zero request is rejected up front
                                    done_reg     <= 1'b1;
                                    status_reg   <= ffsa_pkg::ST_NO_FIT;
                                    out_id_reg   <= '0;
                                    out_size_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_SCAN_RD;
                                end
                            end
                            ffsa_pkg::CMD_FREE:     state_reg <= S_SCAN_RD;
                            ffsa_pkg::CMD_COALESCE: state_reg <= S_C_RD;
                            default:                state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_SCAN_RD:
                begin
                    state_reg <= S_SCAN_EV;
                end
                S_SCAN_EV:
                begin
                    if (cmd_reg == ffsa_pkg::CMD_FREE && free_hit)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= ffsa_pkg::ST_FREED;
                        out_id_reg   <= fid_reg;
                        out_size_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else if (cmd_reg == ffsa_pkg::CMD_ALLOC && alloc_hit)
                    begin
                        seg_sz_reg <= ent.size;
                        if (ent.size == want_reg)
                        begin
                            state_reg <= S_MARK;
                        end
                        else if (count_reg == CW'(ffsa_pkg::MAX_SEGMENTS))
                        begin
                            done_reg     <= 1'b1;
                            status_reg   <= ffsa_pkg::ST_FULL;
                            out_id_reg   <= '0;
                            out_size_reg <= '0;
                            state_reg    <= S_IDLE;
                        end
                        else if (last)
                        begin
                            state_reg <= S_SPLIT;
                        end
                        else
                        begin
                            // open a hole after the fit by moving the tail up one
                            jr_reg    <= IW'(count_reg - CW'(1));
                            state_reg <= S_SH_RD;
                        end
                    end
                    else if (last)
                    begin
                        done_reg     <= 1'b1;
                        status_reg   <= (cmd_reg == ffsa_pkg::CMD_FREE) ?
                                        ffsa_pkg::ST_NOT_FOUND : ffsa_pkg::ST_NO_FIT;
                        out_id_reg   <= '0;
                        out_size_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SH_RD:
                begin
                    state_reg <= S_SH_EV;
                end
                S_SH_EV:
                begin
                    if (jr_reg == idx_reg + IW'(1))
                    begin
                        state_reg <= S_SPLIT;
                    end
                    else
                    begin
                        jr_reg    <= jr_reg - IW'(1);
                        state_reg <= S_SH_RD;
                    end
                end
                S_SPLIT:
                begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_MARK;
                end
                S_MARK:
                begin
                    done_reg     <= 1'b1;
                    status_reg   <= ffsa_pkg::ST_ALLOCATED;
                    out_id_reg   <= id_reg;
                    out_size_reg <= 16'(want_reg);
                    id_reg       <= (id_reg == 16'hFFFF) ? 16'd1 : id_reg + 16'd1;
                    state_reg    <= S_IDLE;
                end
                S_C_RD:
                begin
                    state_reg <= S_C_EV;
                end
                S_C_EV:
                begin
                    if (merge)
                    begin
                        acc_reg.size <= acc_reg.size + ent.size;
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            wr_reg <= wr_reg + IW'(1);
                        end
                        acc_reg  <= ent;
                        have_reg <= 1'b1;
                    end
                    if (last)
                    begin
                        state_reg <= S_C_END;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IW'(1);
                        state_reg <= S_C_RD;
                    end
                end
                S_C_END:
                begin
                    count_reg    <= CW'(wr_reg) + CW'(1);
                    done_reg     <= 1'b1;
                    status_reg   <= ffsa_pkg::ST_COALESCED;
                    out_id_reg   <= '0;
                    out_size_reg <= '0;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign out_id   = out_id_reg;
    assign out_size = out_size_reg;

    // a result is only shown once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer active");

    // table always holds between one and MAX_SEGMENTS entries
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CW'(ffsa_pkg::MAX_SEGMENTS)))
        else $error("segment count out of range");

    // the id counter skips zero
    a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        id_reg != 16'd0)
        else $error("id counter reached zero");

    // a split only happens with room left in the table
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPLIT) |-> (count_reg < CW'(ffsa_pkg::MAX_SEGMENTS)))
        else $error("split on a full table");

endmodule
